[rtl/hbs_pkg.sv]
`timescale 1ns / 1ps
// hbs_pkg: shared widths, command codes and register indexes of the heightfield sampler
// no dependencies

package hbs_pkg;

   localparam int CMD_W      = 2;
   localparam int INDEX_W    = 14;
   localparam int HEIGHT_W   = 32;
   localparam int COORD_W    = 32;
   localparam int EXTENT_W   = 31;
   localparam int SIDE_W     = 8;
   localparam int FRAC_W     = 16;
   localparam int NORM_W     = FRAC_W + 1;
   localparam int NUM_W      = COORD_W + 2;
   localparam int DEN_W      = EXTENT_W + 1;
   localparam int DIV_STEPS  = FRAC_W;
   localparam int CNT_W      = $clog2(DIV_STEPS + 1);
   localparam int MUL_A_W    = HEIGHT_W + 1;
   localparam int MUL_B_W    = NORM_W + 1;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;
   localparam int ROW_W      = 2 * SIDE_W;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << FRAC_W;

   localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   localparam logic REG_EXTENT = 1'b0;
   localparam logic REG_SIDE   = 1'b1;

   localparam logic [EXTENT_W-1:0] EXTENT_RESET = 31'd65536;
   localparam logic [SIDE_W-1:0]   SIDE_RESET   = 8'd128;

endpackage

[rtl/hbs_if.sv]
`timescale 1ns / 1ps
// hbs_req_if, hbs_rsp_if: valid/ready channels of the heightfield sampler
// depends on hbs_pkg

interface hbs_req_if import hbs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [CMD_W-1:0]           cmd;
   logic [INDEX_W-1:0]         entry_index;
   logic signed [HEIGHT_W-1:0] height_value;
   logic signed [COORD_W-1:0]  world_x;
   logic signed [COORD_W-1:0]  world_z;

   modport source (output valid, cmd, entry_index, height_value, world_x, world_z,
                   input ready);
   modport sink (input valid, cmd, entry_index, height_value, world_x, world_z,
                 output ready);
endinterface

interface hbs_rsp_if import hbs_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [HEIGHT_W-1:0] sampled_height;
   logic                       grid_present;

   modport source (output valid, sampled_height, grid_present, input ready);
   modport sink (input valid, sampled_height, grid_present, output ready);
endinterface

[rtl/hbs_div.sv]
`timescale 1ns / 1ps
// hbs_div: restoring divider giving the clamped Q1.16 position num/den, one bit per cycle
// depends on hbs_pkg

module hbs_div import hbs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic [DEN_W-1:0]        den,
   output logic                    done,
   output logic [NORM_W-1:0]       quot
);

   logic               busy_ff;
   logic               done_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [NORM_W-1:0]  quot_ff;

   logic [DEN_W:0]     rem_dbl;
   logic [DEN_W:0]     rem_sub;
   logic               rem_ge;

   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, den_ff};
   assign rem_ge  = rem_dbl >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            if (num[NUM_W-1] || num == '0) begin
               quot_ff <= '0;
               done_ff <= 1'b1;
            end else if ($unsigned(num) >= {2'b00, den}) begin
               quot_ff <= NORM_ONE;
               done_ff <= 1'b1;
            end else begin
               rem_ff  <= num[DEN_W-1:0];
               den_ff  <= den;
               quot_ff <= '0;
               cnt_ff  <= CNT_W'(DIV_STEPS);
               busy_ff <= 1'b1;
            end
         end else if (busy_ff) begin
            rem_ff  <= rem_ge ? rem_sub[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
            quot_ff <= {quot_ff[NORM_W-2:0], rem_ge};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

[rtl/hbs_mul.sv]
`timescale 1ns / 1ps
// hbs_mul: shared signed multiplier with registered product
// depends on hbs_pkg

module hbs_mul import hbs_pkg::*; (
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] mul_a,
   input  logic signed [MUL_B_W-1:0] mul_b,
   output logic signed [PROD_W-1:0]  prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   assign prod = prod_ff;

endmodule

[rtl/hbs_grid_mem.sv]
`timescale 1ns / 1ps
// hbs_grid_mem: height grid storage, one write and one registered read port
// depends on hbs_pkg

module hbs_grid_mem import hbs_pkg::*; #(
   parameter int ADDR_W = 14
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [ADDR_W-1:0]          wr_addr,
   input  logic signed [HEIGHT_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]          rd_addr,
   output logic signed [HEIGHT_W-1:0] rd_data
);

   logic signed [HEIGHT_W-1:0] mem [2**ADDR_W];
   logic signed [HEIGHT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/heightfield_bilinear_sampler.sv]
`timescale 1ns / 1ps
// Heightfield bilinear sampler: holds one square grid of Q16.16 heights and returns bilinear
// samples. Writes and clears complete on their transfer. A sample with a grid held runs
// each coordinate through the 16-step divider in turn, skipping the steps for a coordinate
// that lies on or beyond the grid edge; then one shared multiplier does the cell split, the
// row addresses and the three blends while four grid reads go through the single read port.
// A sample with no grid held answers in the cycle after its transfer. The input stays
// closed while a result waits to be taken. Depends on hbs_pkg and hbs_if.

module heightfield_bilinear_sampler import hbs_pkg::*; #(
   parameter int MAX_SIDE = 128
) (
   input  logic               clock,
   input  logic               reset,
   hbs_req_if.sink            req,
   hbs_rsp_if.source          rsp,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE, S_XSTART, S_XWAIT, S_ZSTART, S_ZWAIT, S_MULX, S_MULZ, S_ROW0, S_ROW1,
      S_RD00, S_RD10, S_RD01, S_RD11, S_L0, S_L1, S_L2, S_L3, S_FIN
   } state_type;

   state_type                  state_ff;
   logic [EXTENT_W-1:0]        extent_ff;
   logic [SIDE_W-1:0]          side_ff;
   logic                       grid_valid_ff;
   logic signed [COORD_W-1:0]  wx_ff;
   logic signed [COORD_W-1:0]  wz_ff;
   logic [NORM_W-1:0]          normx_ff;
   logic [NORM_W-1:0]          normz_ff;
   logic [SIDE_W-1:0]          x0_ff;
   logic [SIDE_W-1:0]          x1_ff;
   logic [SIDE_W-1:0]          z1_ff;
   logic [FRAC_W-1:0]          fx_ff;
   logic [FRAC_W-1:0]          fz_ff;
   logic [ROW_W-1:0]           row0_ff;
   logic [ROW_W-1:0]           row1_ff;
   logic signed [HEIGHT_W-1:0] h00_ff;
   logic signed [HEIGHT_W-1:0] h10_ff;
   logic signed [HEIGHT_W-1:0] h01_ff;
   logic signed [HEIGHT_W-1:0] h11_ff;
   logic signed [HEIGHT_W-1:0] h0_ff;
   logic signed [HEIGHT_W-1:0] h1_ff;
   logic                       rsp_valid_ff;
   logic signed [HEIGHT_W-1:0] rsp_height_ff;
   logic                       rsp_present_ff;

   logic [SIDE_W-1:0]          side_eff;
   logic [SIDE_W-1:0]          last;
   logic [EXTENT_W-1:0]        ext_eff;
   logic [DEN_W-1:0]           den;
   logic signed [NUM_W-1:0]    num_x;
   logic signed [NUM_W-1:0]    num_z;
   logic                       div_start;
   logic signed [NUM_W-1:0]    div_num;
   logic                       div_done;
   logic [NORM_W-1:0]          div_quot;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic [SIDE_W-1:0]          cell_idx;
   logic [SIDE_W:0]            cell_inc;
   logic [SIDE_W-1:0]          cell_up;
   logic [ROW_W:0]             rd_sum;
   logic [ADDR_W-1:0]          rd_addr;
   logic signed [HEIGHT_W-1:0] rd_data;
   logic                       wr_en;
   logic                       req_fire;
   logic                       rsp_fire;
   logic                       out_free;
   logic                       cfg_write;

   // effective configuration
   always_comb begin
      side_eff = side_ff;
      if (side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (32'(side_ff) > MAX_SIDE) begin
         side_eff = SIDE_W'(MAX_SIDE);
      end
   end

   assign last    = side_eff - 1'b1;
   assign ext_eff = (extent_ff == '0) ? EXTENT_W'(1) : extent_ff;
   assign den     = {ext_eff, 1'b0};
   assign num_x   = $signed({wx_ff[COORD_W-1], wx_ff, 1'b0}) + $signed({3'b000, ext_eff});
   assign num_z   = $signed({wz_ff[COORD_W-1], wz_ff, 1'b0}) + $signed({3'b000, ext_eff});

   assign div_start = (state_ff == S_XSTART) || (state_ff == S_ZSTART);
   assign div_num   = (state_ff == S_ZSTART) ? num_z : num_x;

   // upper neighbour of the cell held in the product, clamped to the last vertex
   assign cell_idx = prod[FRAC_W+SIDE_W-1:FRAC_W];
   assign cell_inc = {1'b0, cell_idx} + 1'b1;
   assign cell_up  = (cell_inc < {1'b0, last}) ? cell_inc[SIDE_W-1:0] : last;

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MULX: begin
            mul_a = $signed(MUL_A_W'(last));
            mul_b = $signed({1'b0, normx_ff});
         end
         S_MULZ: begin
            mul_a = $signed(MUL_A_W'(last));
            mul_b = $signed({1'b0, normz_ff});
         end
         S_ROW0: begin
            mul_a = $signed(MUL_A_W'(side_eff));
            mul_b = $signed(MUL_B_W'(cell_idx));
         end
         S_ROW1: begin
            mul_a = $signed(MUL_A_W'(side_eff));
            mul_b = $signed(MUL_B_W'(z1_ff));
         end
         S_L0: begin
            mul_a = {h10_ff[HEIGHT_W-1], h10_ff} - {h00_ff[HEIGHT_W-1], h00_ff};
            mul_b = $signed({2'b00, fx_ff});
         end
         S_L1: begin
            mul_a = {h11_ff[HEIGHT_W-1], h11_ff} - {h01_ff[HEIGHT_W-1], h01_ff};
            mul_b = $signed({2'b00, fx_ff});
         end
         S_L3: begin
            mul_a = {h1_ff[HEIGHT_W-1], h1_ff} - {h0_ff[HEIGHT_W-1], h0_ff};
            mul_b = $signed({2'b00, fz_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // grid read address
   always_comb begin
      case (state_ff)
         S_RD00:  rd_sum = {1'b0, row0_ff} + (ROW_W+1)'(x0_ff);
         S_RD10:  rd_sum = {1'b0, row0_ff} + (ROW_W+1)'(x1_ff);
         S_RD01:  rd_sum = {1'b0, row1_ff} + (ROW_W+1)'(x0_ff);
         S_RD11:  rd_sum = {1'b0, row1_ff} + (ROW_W+1)'(x1_ff);
         default: rd_sum = '0;
      endcase
   end

   assign rd_addr = ADDR_W'(rd_sum);

   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp_valid_ff && rsp.ready;
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign wr_en     = req_fire && (req.cmd == CMD_WRITE)
                      && ({18'b0, req.entry_index} < 32'(DEPTH));
   assign cfg_write = psel && penable && pwrite && pready;

   hbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (den),
      .done  (div_done),
      .quot  (div_quot)
   );

   hbs_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   hbs_grid_mem #(
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req.entry_index)),
      .wr_data (req.height_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         extent_ff <= EXTENT_RESET;
         side_ff   <= SIDE_RESET;
      end else if (cfg_write) begin
         unique case (paddr[2])
            REG_EXTENT: extent_ff <= pwdata[EXTENT_W-1:0];
            REG_SIDE:   side_ff   <= pwdata[SIDE_W-1:0];
            default:    extent_ff <= extent_ff;
         endcase
      end
   end

   assign prdata = (paddr[2] == REG_SIDE) ? PDATA_W'(side_ff) : PDATA_W'(extent_ff);
   assign pready = 1'b1;

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         grid_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  wx_ff <= req.world_x;
                  wz_ff <= req.world_z;
                  case (req.cmd)
                     CMD_WRITE: begin
                        if (wr_en) begin
                           grid_valid_ff <= 1'b1;
                        end
                     end
                     CMD_CLEAR: grid_valid_ff <= 1'b0;
                     CMD_SAMPLE: begin
                        if (grid_valid_ff) begin
                           state_ff <= S_XSTART;
                        end else begin
                           rsp_valid_ff   <= 1'b1;
                           rsp_height_ff  <= '0;
                           rsp_present_ff <= 1'b0;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_XSTART: state_ff <= S_XWAIT;
            S_XWAIT: begin
               if (div_done) begin
                  normx_ff <= div_quot;
                  state_ff <= S_ZSTART;
               end
            end
            S_ZSTART: state_ff <= S_ZWAIT;
            S_ZWAIT: begin
               if (div_done) begin
                  normz_ff <= div_quot;
                  state_ff <= S_MULX;
               end
            end
            S_MULX: state_ff <= S_MULZ;
            S_MULZ: begin
               x0_ff    <= cell_idx;
               x1_ff    <= cell_up;
               fx_ff    <= prod[FRAC_W-1:0];
               state_ff <= S_ROW0;
            end
            S_ROW0: begin
               z1_ff    <= cell_up;
               fz_ff    <= prod[FRAC_W-1:0];
               state_ff <= S_ROW1;
            end
            S_ROW1: begin
               row0_ff  <= prod[ROW_W-1:0];
               state_ff <= S_RD00;
            end
            S_RD00: begin
               row1_ff  <= prod[ROW_W-1:0];
               state_ff <= S_RD10;
            end
            S_RD10: begin
               h00_ff   <= rd_data;
               state_ff <= S_RD01;
            end
            S_RD01: begin
               h10_ff   <= rd_data;
               state_ff <= S_RD11;
            end
            S_RD11: begin
               h01_ff   <= rd_data;
               state_ff <= S_L0;
            end
            S_L0: begin
               h11_ff   <= rd_data;
               state_ff <= S_L1;
            end
            S_L1: begin
               h0_ff    <= h00_ff + prod[FRAC_W+HEIGHT_W-1:FRAC_W];
               state_ff <= S_L2;
            end
            S_L2: begin
               h1_ff    <= h01_ff + prod[FRAC_W+HEIGHT_W-1:FRAC_W];
               state_ff <= S_L3;
            end
            S_L3: state_ff <= S_FIN;
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_height_ff  <= h0_ff + prod[FRAC_W+HEIGHT_W-1:FRAC_W];
                  rsp_present_ff <= 1'b1;
                  state_ff       <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req.ready          = (state_ff == S_IDLE) && out_free;
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.sampled_height = rsp_height_ff;
   assign rsp.grid_present   = rsp_present_ff;

`ifndef SYNTHESIS
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !req.ready)
      else $error("input ready while a sample is in progress");

   a_div_done_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_XWAIT || state_ff == S_ZWAIT))
      else $error("divider finished outside a wait state");

   a_absent_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_present_ff) |-> (rsp_height_ff == '0))
      else $error("nonzero height without a grid");

   a_no_result_for_write: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.cmd != CMD_SAMPLE && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result produced by a write or clear");
`endif

endmodule

[tb/sv/heightfield_bilinear_sampler_test.sv]
`timescale 1ns / 1ps
// heightfield_bilinear_sampler_test: self-checking bench for the heightfield bilinear sampler,
// with a bit-exact height predictor, random traffic under idling and a long receiver stall.
// depends on hbs_pkg, hbs_if and heightfield_bilinear_sampler

module heightfield_bilinear_sampler_test;
   import hbs_pkg::*;

   localparam int GRID_MAX      = 128;
   localparam int GRID_DEPTH    = GRID_MAX * GRID_MAX;
   localparam int SETTLE_CYCLES = 80;
   localparam int END_SETTLE    = 100;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 80;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int SEND_IDLE [3] = '{29, 53, 0};
   localparam int RECV_IDLE [3] = '{53, 29, 0};
   localparam logic [31:0] EXTENTS [9] = '{32'h0008_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                         32'h0001_0000, 32'h00C0_0000, 32'h0000_0003,
                                         32'h7FFF_FFFF, 32'h0012_D687, 32'h0064_0000};
   localparam logic [7:0] SIDES [9] = '{8'd9, 8'd128, 8'd2, 8'd1, 8'd255, 8'd0,
                                      8'd64, 8'd33, 8'd129};

   typedef struct {
      logic signed [HEIGHT_W-1:0] height;
      logic                       present;
   } height_result_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   hbs_req_if req ();
   hbs_rsp_if rsp ();

   heightfield_bilinear_sampler #(.MAX_SIDE(GRID_MAX)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req.sink),
      .rsp     (rsp.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // predictor state
   logic signed [HEIGHT_W-1:0] grid_heights [GRID_DEPTH];
   bit                         entry_written [GRID_DEPTH];
   bit                         grid_held;
   logic [EXTENT_W-1:0]        extent_reg;
   logic [SIDE_W-1:0]          side_reg;

   height_result_type expected_heights [$];
   height_result_type next_due;

   int errors;
   int cycle_count;
   int send_idle_pct;
   int recv_idle_pct;
   int stall_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint expected, input longint got);
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, expected, got);
      errors++;
   endtask

   function automatic longint extent_eff();
      return (extent_reg == 0) ? 64'sd1 : longint'(extent_reg);
   endfunction

   function automatic int side_eff();
      if (side_reg == 0) return 1;
      if (side_reg > GRID_MAX) return GRID_MAX;
      return int'(side_reg);
   endfunction

   function automatic longint norm_q16(input longint pos);
      longint num;
      longint den;
      num = 2 * pos + extent_eff();
      den = 2 * extent_eff();
      if (num <= 0) return 0;
      if (num >= den) return 65536;
      return (num <<< 16) / den;
   endfunction

   function automatic void locate(input logic signed [COORD_W-1:0] x, z, output int cells [4],
                                  output longint fx, fz);
      int     s, last, x0, x1, z0, z1;
      longint px, pz;
      s = side_eff();
      last = s - 1;
      px = norm_q16(x) * last;
      pz = norm_q16(z) * last;
      x0 = int'(px >>> 16);
      z0 = int'(pz >>> 16);
      fx = px & 64'hFFFF;
      fz = pz & 64'hFFFF;
      x1 = (x0 + 1 < last) ? x0 + 1 : last;
      z1 = (z0 + 1 < last) ? z0 + 1 : last;
      cells[0] = z0 * s + x0;
      cells[1] = z0 * s + x1;
      cells[2] = z1 * s + x0;
      cells[3] = z1 * s + x1;
   endfunction

   // floor of the product keeps the blend between its endpoints
   function automatic longint blend(input longint a, b, f);
      return a + (((b - a) * f) >>> 16);
   endfunction

   function automatic height_result_type predict_height(input logic signed [COORD_W-1:0] x, z);
      int                cells [4];
      longint            fx, fz, h0, h1;
      height_result_type r;
      r.height = '0;
      r.present = 1'b0;
      if (grid_held) begin
         locate(x, z, cells, fx, fz);
         h0 = blend(grid_heights[cells[0]], grid_heights[cells[1]], fx);
         h1 = blend(grid_heights[cells[2]], grid_heights[cells[3]], fx);
         r.height = HEIGHT_W'(blend(h0, h1, fz));
         r.present = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [HEIGHT_W-1:0] rand_height();
      case ($urandom_range(9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      longint e;
      e = extent_eff();
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         2: return COORD_W'(($urandom_range(1) ? e : -e) / 2);
         default: return COORD_W'(longint'($urandom_range(e)) - e / 2);
      endcase
   endfunction

   // callers enter at a falling edge, the task returns at a falling edge
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [INDEX_W-1:0] idx,
                            input logic signed [HEIGHT_W-1:0] h,
                            input logic signed [COORD_W-1:0] x, z);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.entry_index <= idx;
      req.height_value <= h;
      req.world_x <= x;
      req.world_z <= z;
      do @(posedge clock); while (req.ready !== 1'b1);
      case (cmd)
         CMD_WRITE: begin
            grid_heights[idx] = h;
            entry_written[idx] = 1'b1;
            grid_held = 1'b1;
         end
         CMD_CLEAR: grid_held = 1'b0;
         CMD_SAMPLE: expected_heights.insert(expected_heights.size(), predict_height(x, z));
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic write_entry(input int idx, input logic signed [HEIGHT_W-1:0] h);
      send_item(CMD_WRITE, INDEX_W'(idx), h, $urandom, $urandom);
   endtask

   task automatic clear_grid();
      send_item(CMD_CLEAR, INDEX_W'($urandom), $urandom, $urandom, $urandom);
   endtask

   // never let a sample touch an entry that was not written since reset
   task automatic sample_at(input logic signed [COORD_W-1:0] x, z);
      int     cells [4];
      longint fx, fz;
      if (grid_held) begin
         locate(x, z, cells, fx, fz);
         foreach (cells[i])
            if (!entry_written[cells[i]]) write_entry(cells[i], rand_height());
      end
      send_item(CMD_SAMPLE, INDEX_W'($urandom), $urandom, x, z);
   endtask

   task automatic set_csr(input logic reg_sel, input logic [PDATA_W-1:0] data);
      logic [PDATA_W-1:0] readback;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (reg_sel == REG_EXTENT) begin
         extent_reg = data[EXTENT_W-1:0];
         readback = PDATA_W'(data[EXTENT_W-1:0]);
      end else begin
         side_reg = data[SIDE_W-1:0];
         readback = PDATA_W'(data[SIDE_W-1:0]);
      end
      @(negedge clock);
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== readback) report_mismatch("csr readback", readback, prdata);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic wait_idle(input int settle);
      req.valid <= 1'b0;
      while (expected_heights.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_setting(input logic [31:0] extent, input logic [7:0] side);
      wait_idle(SETTLE_CYCLES);
      set_csr(REG_EXTENT, {1'($urandom), extent[30:0]});
      set_csr(REG_SIDE, {24'($urandom), side});
   endtask

   task automatic test_empty_grid();
      sample_at(32'sh8000_0000, 32'sh7FFF_FFFF);
      send_item(CMD_UNUSED, INDEX_W'($urandom), $urandom, $urandom, $urandom);
      sample_at(32'sh0, 32'sh0);
   endtask

   // opposite extremes in one cell stress the signed blend
   task automatic test_signed_blend();
      write_entry(0, 32'sh7FFF_FFFF);
      write_entry(1, 32'sh8000_0000);
      write_entry(GRID_MAX, 32'sh8000_0000);
      write_entry(GRID_MAX + 1, 32'sh7FFF_FFFF);
      sample_at(-32'sd32768, -32'sd32768);
      sample_at(-32'sd32252, -32'sd32252);
      sample_at(-32'sd32252, -32'sd32768);
      sample_at(-32'sd32768, -32'sd32252);
      sample_at(32'sd32767, -32'sd40000);
      sample_at(32'sd32768, 32'sd32768);
   endtask

   task automatic test_clear_keeps_memory();
      clear_grid();
      sample_at(-32'sd32252, -32'sd32252);
      write_entry(GRID_DEPTH - 1, rand_height());
      sample_at(-32'sd32252, -32'sd32252);
   endtask

   task automatic test_register_extremes();
      apply_setting(32'h0000_0000, 8'd1);
      sample_at(rand_coord(), rand_coord());
      sample_at(32'sh7FFF_FFFF, 32'sh8000_0000);
      apply_setting(32'hFFFF_FFFF, 8'd0);
      sample_at(rand_coord(), rand_coord());
      apply_setting(32'h0000_0001, 8'd255);
      sample_at(32'sh0, 32'sh1);
      sample_at(rand_coord(), rand_coord());
      apply_setting(32'h0001_0000, 8'd2);
      sample_at(rand_coord(), rand_coord());
      sample_at(rand_coord(), rand_coord());
   endtask

   task automatic random_traffic(input int count);
      int pick;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 50)
            sample_at(rand_coord(), rand_coord());
         else if (pick < 85)
            write_entry($urandom_range(side_eff() * side_eff() - 1), rand_height());
         else if (pick < 90)
            write_entry($urandom_range(GRID_DEPTH - 1), rand_height());
         else if (pick < 96)
            clear_grid();
         else
            send_item(CMD_UNUSED, INDEX_W'($urandom), $urandom, $urandom, $urandom);
      end
   endtask

   // receiver holds off while the sender keeps offering samples
   task automatic test_backpressure();
      apply_setting(32'h0004_0000, 8'd16);
      write_entry(0, rand_height());
      @(posedge clock);
      stall_left = 400;
      @(negedge clock);
      repeat (40) sample_at(rand_coord(), rand_coord());
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (expected_heights.size() == 0) begin
            report_mismatch("transfer with none expected, height", 0, rsp.sampled_height);
         end else begin
            next_due = expected_heights.pop_front();
            if (rsp.sampled_height !== next_due.height)
               report_mismatch("sampled_height", next_due.height, rsp.sampled_height);
            if (rsp.grid_present !== next_due.present)
               report_mismatch("grid_present", next_due.present, rsp.grid_present);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("heightfield_bilinear_sampler_test failed");
      $finish;
   end

   initial begin
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req.valid = 1'b0;
      req.cmd = CMD_WRITE;
      req.entry_index = '0;
      req.height_value = '0;
      req.world_x = '0;
      req.world_z = '0;
      rsp.ready = 1'b0;
      grid_held = 1'b0;
      extent_reg = EXTENT_RESET;
      side_reg = SIDE_RESET;
      send_idle_pct = SEND_IDLE[0];
      recv_idle_pct = RECV_IDLE[0];
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_grid();
      test_signed_blend();
      test_clear_keeps_memory();
      test_register_extremes();
      for (int m = 0; m < 3; m++) begin
         send_idle_pct = SEND_IDLE[m];
         recv_idle_pct = RECV_IDLE[m];
         for (int k = 0; k < 3; k++) begin
            apply_setting(EXTENTS[3 * m + k], SIDES[3 * m + k]);
            random_traffic(RANDOM_ITEMS);
         end
      end
      test_backpressure();

      wait_idle(END_SETTLE);
      if (errors == 0)
         $display("heightfield_bilinear_sampler_test passed");
      else
         $display("heightfield_bilinear_sampler_test failed");
      $finish;
   end

endmodule

[heightfield_bilinear_sampler.f]
rtl/hbs_pkg.sv
rtl/hbs_if.sv
rtl/hbs_div.sv
rtl/hbs_mul.sv
rtl/hbs_grid_mem.sv
rtl/heightfield_bilinear_sampler.sv
tb/sv/heightfield_bilinear_sampler_test.sv
